### src/fdpl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frame difference peak locator.
// No dependencies; every module of the block imports this package.
package fdpl_pkg;

	localparam int unsigned COORD_BITS = 12;
	localparam int unsigned CFG_BITS   = 13;
	localparam int unsigned PIX_BITS   = 8;
	localparam int unsigned SQ_BITS    = 2 * PIX_BITS;
	localparam int unsigned SUM_BITS   = SQ_BITS + 2;
	localparam int unsigned VAL_BITS   = SQ_BITS;
	localparam int unsigned ROOT_BITS  = VAL_BITS / 2;
	localparam int unsigned COORD_SPAN = 1 << COORD_BITS;

	// floor(x / 3) = (x * ceil(2^19 / 3)) >> 19, exact for x below 2^19
	localparam int unsigned DIV3_SHIFT = 19;
	localparam int unsigned PROD_BITS  = 2 * SUM_BITS;
	localparam logic [SUM_BITS-1:0] DIV3_RECIP = SUM_BITS'(((1 << DIV3_SHIFT) + 2) / 3);

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1280);
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(720);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] first_ch0;
		logic [PIX_BITS-1:0] first_ch1;
		logic [PIX_BITS-1:0] first_ch2;
		logic [PIX_BITS-1:0] second_ch0;
		logic [PIX_BITS-1:0] second_ch1;
		logic [PIX_BITS-1:0] second_ch2;
	} pix_beat_t;

	typedef struct packed {
		logic [ROOT_BITS-1:0]  diff_value;
		logic                  frame_done;
		logic [ROOT_BITS-1:0]  peak_value;
		logic [COORD_BITS-1:0] peak_row;
		logic [COORD_BITS-1:0] peak_col;
	} res_beat_t;

	// One slot of the square-root chain: operand and partial root.
	typedef struct packed {
		logic                 valid;
		logic [VAL_BITS-1:0]  value;
		logic [ROOT_BITS-1:0] root;
	} sqrt_slot_t;

	// Last valid index for a size register: zero acts as one, oversize clamps.
	function automatic logic [COORD_BITS-1:0] last_index(input logic [CFG_BITS-1:0] size);
		logic [CFG_BITS-1:0] dec;
		dec = size - 1'b1;
		if (size == '0)
			return '0;
		if (32'(size) > COORD_SPAN)
			return '1;
		return COORD_BITS'(dec);
	endfunction

endpackage

### src/fdpl_front.sv
`timescale 1ns / 1ps
// Front end: channel differences, squares, sum and exact divide by three.
// Depends on fdpl_pkg; feeds the first cell of the square-root chain.
module fdpl_front
	import fdpl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       take,
	input  pix_beat_t  pix,
	output sqrt_slot_t slot
);

	logic                valid_s1;
	logic [SQ_BITS-1:0]  sq0_s1, sq1_s1, sq2_s1;
	logic                valid_s2;
	logic [SUM_BITS-1:0] sum_s2;
	logic                valid_s3;
	logic [VAL_BITS-1:0] quot_s3;

	logic [PIX_BITS-1:0]  d0, d1, d2;
	logic [PROD_BITS-1:0] prod;

	always_comb begin
		d0 = (pix.first_ch0 > pix.second_ch0) ? pix.first_ch0 - pix.second_ch0
		                                      : pix.second_ch0 - pix.first_ch0;
		d1 = (pix.first_ch1 > pix.second_ch1) ? pix.first_ch1 - pix.second_ch1
		                                      : pix.second_ch1 - pix.first_ch1;
		d2 = (pix.first_ch2 > pix.second_ch2) ? pix.first_ch2 - pix.second_ch2
		                                      : pix.second_ch2 - pix.first_ch2;
		prod = PROD_BITS'(sum_s2) * PROD_BITS'(DIV3_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq0_s1  <= SQ_BITS'(d0) * SQ_BITS'(d0);
			sq1_s1  <= SQ_BITS'(d1) * SQ_BITS'(d1);
			sq2_s1  <= SQ_BITS'(d2) * SQ_BITS'(d2);
			sum_s2  <= SUM_BITS'(sq0_s1) + SUM_BITS'(sq1_s1) + SUM_BITS'(sq2_s1);
			quot_s3 <= prod[DIV3_SHIFT +: VAL_BITS];
		end
	end

	assign slot.valid = valid_s3;
	assign slot.value = quot_s3;
	assign slot.root  = '0;

endmodule

### src/fdpl_sqrt_cell.sv
`timescale 1ns / 1ps
// One cell of the square-root chain: settles one root bit, then hands on.
// Depends on fdpl_pkg for the slot type.
module fdpl_sqrt_cell
	import fdpl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [ROOT_BITS-1:0] bit_sel,
	input  sqrt_slot_t           slot_in,
	output sqrt_slot_t           slot_out
);

	logic [ROOT_BITS-1:0] trial;
	logic [VAL_BITS-1:0]  trial_sq;
	logic                 valid_q;
	logic [VAL_BITS-1:0]  value_q;
	logic [ROOT_BITS-1:0] root_q;

	always_comb begin
		trial    = slot_in.root | bit_sel;
		trial_sq = VAL_BITS'(trial) * VAL_BITS'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= slot_in.valid;
		end
	end

	// keep the bit only while its square stays within the operand
	always_ff @(posedge clk) begin
		if (adv) begin
			value_q <= slot_in.value;
			root_q  <= (trial_sq <= slot_in.value) ? trial : slot_in.root;
		end
	end

	assign slot_out.valid = valid_q;
	assign slot_out.value = value_q;
	assign slot_out.root  = root_q;

endmodule

### src/fdpl_peak.sv
`timescale 1ns / 1ps
// Peak tracker: size registers, raster counters, running peak and the
// output register. Depends on fdpl_pkg.
module fdpl_peak
	import fdpl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  sqrt_slot_t          slot,
	output logic                adv,
	output logic                res_valid,
	input  logic                res_stall,
	output res_beat_t           res
);

	logic [CFG_BITS-1:0]   width_q, height_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic [ROOT_BITS-1:0]  best_q;
	logic [COORD_BITS-1:0] best_row_q, best_col_q;
	logic                  res_valid_q;
	res_beat_t             res_q;

	logic [COORD_BITS-1:0] last_col, last_row;
	logic                  row_end, done, upd, step;
	logic [ROOT_BITS-1:0]  nbest;
	logic [COORD_BITS-1:0] nrow, ncol;

	assign adv  = !res_valid_q || !res_stall;
	assign step = adv && slot.valid;

	always_comb begin
		last_col = last_index(width_q);
		last_row = last_index(height_q);
		row_end  = col_q >= last_col;
		done     = row_end && (row_q >= last_row);
		upd      = slot.root > best_q;
		nbest    = upd ? slot.root : best_q;
		nrow     = upd ? row_q : best_row_q;
		ncol     = upd ? col_q : best_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			best_q      <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv)
				res_valid_q <= slot.valid;
			if (step) begin
				if (done) begin
					col_q      <= '0;
					row_q      <= '0;
					best_q     <= '0;
					best_row_q <= '0;
					best_col_q <= '0;
				end else begin
					best_q     <= nbest;
					best_row_q <= nrow;
					best_col_q <= ncol;
					if (row_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.diff_value <= slot.root;
			res_q.frame_done <= done;
			res_q.peak_value <= nbest;
			res_q.peak_row   <= nrow;
			res_q.peak_col   <= ncol;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> col_q == '0 && row_q == '0 && best_q == '0)
		else $error("frame end did not clear peak and counters");

	a_peak_covers_diff: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.peak_value >= res_q.diff_value)
		else $error("peak below current difference");

	a_zero_peak_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.peak_value == '0 |-> res_q.peak_row == '0 && res_q.peak_col == '0)
		else $error("zero peak away from origin");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot.valid |-> (VAL_BITS'(slot.root) * VAL_BITS'(slot.root)) <= slot.value)
		else $error("root squared exceeds operand");
`endif

endmodule

### src/frame_diff_peak_locator.sv
`timescale 1ns / 1ps
// Top level of the frame difference peak locator: front end, square-root
// cell chain and peak tracker. Depends on fdpl_pkg and the fdpl_* modules.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  pix     | pix_valid / pix_stall | pix_beat_t, both frames' pixel
//  res     | res_valid / res_stall | res_beat_t, value and peak
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel beat per cycle unless a held result stalls; each beat passes
// through three front stages (squares, sum, divide by three), eight root
// cells and the output register.
// Reset clears the counters and the running peak and loads 1280 x 720.
// A held result stalls all stages; pix_stall = res_valid && res_stall.
module frame_diff_peak_locator
	import fdpl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  pix_beat_t           pix,
	output logic                res_valid,
	input  logic                res_stall,
	output res_beat_t           res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	logic       adv;
	sqrt_slot_t chain [ROOT_BITS+1];

	assign pix_stall = !adv;
	assign cfg_ready = 1'b1;

	fdpl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.take   (pix_valid),
		.pix    (pix),
		.slot   (chain[0])
	);

	// most significant root bit first
	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
		fdpl_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.bit_sel  (ROOT_BITS'(1) << (ROOT_BITS - 1 - i)),
			.slot_in  (chain[i]),
			.slot_out (chain[i+1])
		);
	end

	fdpl_peak u_peak (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.slot      (chain[ROOT_BITS]),
		.adv       (adv),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
